### hdl/dual_sensor_moving_average_defines.svh
// Assertion macros used by the file that checks its own logic.
`ifndef DUAL_SENSOR_MOVING_AVERAGE_DEFINES_SVH
`define DUAL_SENSOR_MOVING_AVERAGE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define DSMA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define DSMA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define DSMA_ASSERT(label, prop, msg)
`define DSMA_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

### hdl/dsma_pkg.sv
`timescale 1ns / 1ps

package dsma_pkg;

    localparam int WINDOW_LEN_DEF  = 8;
    localparam int SAMPLE_BITS_DEF = 10;

    localparam int ZERO_BITS      = 10;
    localparam int GAIN_BITS      = 16;
    localparam int TEMP_BITS      = 19;
    localparam int LEVEL_BITS     = 3;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    localparam int Q_SHIFT     = 8;
    localparam int ONE_Q16     = 65536;
    localparam int LEVEL_STEP  = 5;
    localparam int LEVEL_COUNT = 5;
    localparam int TEMP_MAX    = 262143;
    localparam int TEMP_MIN    = -262144;

    localparam int ZERO_RST = 200;
    localparam int GAIN_RST = 6717;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_TEMP_ZERO = 2'd0,
        REG_TEMP_GAIN = 2'd1,
        REG_BATT_ZERO = 2'd2,
        REG_BATT_GAIN = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic rd;
        logic upd;
        logic start;
        logic full;
    } t_chan_ctrl;

endpackage

### hdl/dsma_divider.sv
`timescale 1ns / 1ps

module dsma_divider
    import dsma_pkg::*;
#(
    parameter int NUM_BITS = 13,
    parameter int DEN_BITS = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NUM_BITS-1:0] i_num,
    input  logic [DEN_BITS-1:0] i_den,
    output logic [NUM_BITS-1:0] o_quo,
    output logic                o_done
);

    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] r_quo;
    logic [DEN_BITS-1:0] r_rem;
    logic [DEN_BITS-1:0] r_den;
    logic [CNT_BITS-1:0] r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [DEN_BITS:0]   w_shifted;
    logic [DEN_BITS:0]   w_diff;
    logic                w_ge;

    assign w_shifted = {r_rem, r_quo[NUM_BITS-1]};
    assign w_diff    = w_shifted - {1'b0, r_den};
    assign w_ge      = (w_shifted >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_BITS'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(NUM_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[NUM_BITS-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DEN_BITS-1:0] : w_shifted[DEN_BITS-1:0];
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;

endmodule

### hdl/dsma_multiplier.sv
`timescale 1ns / 1ps

module dsma_multiplier
    import dsma_pkg::*;
#(
    parameter int A_BITS = 11
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [A_BITS-1:0]          i_a,
    input  logic        [GAIN_BITS-1:0]       i_gain,
    output logic signed [A_BITS+GAIN_BITS-1:0] o_product,
    output logic                              o_done
);

    localparam int P_BITS   = A_BITS + GAIN_BITS;
    localparam int CNT_BITS = $clog2(GAIN_BITS + 1);

    logic signed [A_BITS-1:0] r_a;
    logic [GAIN_BITS-1:0]     r_gain;
    logic signed [P_BITS-1:0] r_acc;
    logic [CNT_BITS-1:0]      r_cnt;
    logic                     r_busy;
    logic                     r_done;
    logic signed [P_BITS-1:0] w_addend;

    assign w_addend = r_gain[GAIN_BITS-1] ? {{GAIN_BITS{r_a[A_BITS-1]}}, r_a} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_BITS'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(GAIN_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Gain bits enter most significant first.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a    <= i_a;
            r_gain <= i_gain;
            r_acc  <= '0;
        end else if (r_busy) begin
            r_gain <= {r_gain[GAIN_BITS-2:0], 1'b0};
            r_acc  <= (r_acc <<< 1) + w_addend;
        end
    end

    assign o_product = r_acc;
    assign o_done    = r_done;

endmodule

### hdl/dsma_channel.sv
`timescale 1ns / 1ps

module dsma_channel
    import dsma_pkg::*;
#(
    parameter int WINDOW_LEN  = WINDOW_LEN_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  t_chan_ctrl                           i_ctrl,
    input  logic [$clog2(WINDOW_LEN)-1:0]        i_slot,
    input  logic [$clog2(WINDOW_LEN+1)-1:0]      i_divisor,
    input  logic [SAMPLE_BITS-1:0]               i_sample,
    input  logic [ZERO_BITS-1:0]                 i_zero,
    input  logic [GAIN_BITS-1:0]                 i_gain,
    output logic signed [((SAMPLE_BITS > ZERO_BITS) ? SAMPLE_BITS : ZERO_BITS)+GAIN_BITS:0]
                                                 o_product,
    output logic                                 o_done
);

    localparam int DEN_BITS  = $clog2(WINDOW_LEN + 1);
    localparam int SUM_BITS  = SAMPLE_BITS + $clog2(WINDOW_LEN);
    localparam int DIFF_BITS = ((SAMPLE_BITS > ZERO_BITS) ? SAMPLE_BITS : ZERO_BITS) + 1;

    logic [SAMPLE_BITS-1:0]  r_ring [WINDOW_LEN];
    logic [SAMPLE_BITS-1:0]  r_old;
    logic [SUM_BITS-1:0]     r_sum;
    logic [SUM_BITS-1:0]     n_sum;
    logic [SUM_BITS-1:0]     w_quo;
    logic                    w_div_done;
    logic signed [DIFF_BITS-1:0] w_diff;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.upd) begin
            r_ring[i_slot] <= i_sample;
        end
        if (i_ctrl.rd) begin
            r_old <= r_ring[i_slot];
        end
    end

    assign n_sum = r_sum - (i_ctrl.full ? SUM_BITS'(r_old) : '0) + SUM_BITS'(i_sample);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_ctrl.upd) begin
            r_sum <= n_sum;
        end
    end

    dsma_divider #(
        .NUM_BITS (SUM_BITS),
        .DEN_BITS (DEN_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctrl.start),
        .i_num   (r_sum),
        .i_den   (i_divisor),
        .o_quo   (w_quo),
        .o_done  (w_div_done)
    );

    assign w_diff = DIFF_BITS'(w_quo[SAMPLE_BITS-1:0]) - DIFF_BITS'(i_zero);

    dsma_multiplier #(
        .A_BITS (DIFF_BITS)
    ) u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_done),
        .i_a       (w_diff),
        .i_gain    (i_gain),
        .o_product (o_product),
        .o_done    (o_done)
    );

endmodule

### hdl/dual_sensor_moving_average.sv
`timescale 1ns / 1ps
// Channel  Handshake                  Payload
// input    i_in_valid / o_in_ready    i_temp_sample, i_batt_sample
// output   o_out_valid / i_out_ready  o_temperature, o_battery_level
// config   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Each channel computes its result in a bit-serial divider followed by a bit-serial multiplier;
// a new sample pair is taken only in the idle state, once the previous one is through.
// Both channels run in lockstep. Reset is synchronous and clears no ring entries.
// A finished result waits in the output register while the next input is taken;
// the block stalls only when a new result is ready and the previous one is still held.

module dual_sensor_moving_average
    import dsma_pkg::*;
#(
    parameter int WINDOW_LEN  = WINDOW_LEN_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [SAMPLE_BITS-1:0]       i_temp_sample,
    input  logic [SAMPLE_BITS-1:0]       i_batt_sample,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [TEMP_BITS-1:0]  o_temperature,
    output logic [LEVEL_BITS-1:0]        o_battery_level,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]     i_cfg_data
);

`include "dual_sensor_moving_average_defines.svh"

    localparam int SLOT_BITS = $clog2(WINDOW_LEN);
    localparam int CNT_BITS  = $clog2(WINDOW_LEN + 1);
    localparam int DIFF_BITS = ((SAMPLE_BITS > ZERO_BITS) ? SAMPLE_BITS : ZERO_BITS) + 1;
    localparam int P_BITS    = DIFF_BITS + GAIN_BITS;
    localparam int Q8_BITS   = P_BITS - Q_SHIFT;

    localparam logic signed [Q8_BITS-1:0] Q8_MAX = Q8_BITS'(TEMP_MAX);
    localparam logic signed [Q8_BITS-1:0] Q8_MIN = Q8_BITS'(TEMP_MIN);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_UPDATE = 5'b00010,
        S_START  = 5'b00100,
        S_CALC   = 5'b01000,
        S_OUTPUT = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [ZERO_BITS-1:0]   r_temp_zero;
    logic [GAIN_BITS-1:0]   r_temp_gain;
    logic [ZERO_BITS-1:0]   r_batt_zero;
    logic [GAIN_BITS-1:0]   r_batt_gain;

    logic [SAMPLE_BITS-1:0] r_temp_sample;
    logic [SAMPLE_BITS-1:0] r_batt_sample;
    logic [CNT_BITS-1:0]    r_fill;
    logic [SLOT_BITS-1:0]   r_slot;
    logic [CNT_BITS-1:0]    r_divisor;

    logic                         r_out_valid;
    logic signed [TEMP_BITS-1:0]  r_temperature;
    logic [LEVEL_BITS-1:0]        r_level;

    logic                         w_in_accept;
    logic                         w_out_free;
    logic                         w_full;
    t_chan_ctrl                   w_ctrl;
    logic signed [P_BITS-1:0]     w_temp_prod;
    logic signed [P_BITS-1:0]     w_batt_prod;
    logic                         w_temp_done;
    logic                         w_batt_done;
    logic signed [P_BITS-1:0]     w_shift;
    logic signed [Q8_BITS-1:0]    w_q8;
    logic signed [TEMP_BITS-1:0]  w_temperature;
    logic [LEVEL_BITS-1:0]        w_level;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_accept = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_full      = (r_fill == CNT_BITS'(WINDOW_LEN));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_zero <= ZERO_BITS'(ZERO_RST);
            r_temp_gain <= GAIN_BITS'(GAIN_RST);
            r_batt_zero <= ZERO_BITS'(ZERO_RST);
            r_batt_gain <= GAIN_BITS'(GAIN_RST);
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_TEMP_ZERO: r_temp_zero <= i_cfg_data[ZERO_BITS-1:0];
                REG_TEMP_GAIN: r_temp_gain <= i_cfg_data[GAIN_BITS-1:0];
                REG_BATT_ZERO: r_batt_zero <= i_cfg_data[ZERO_BITS-1:0];
                REG_BATT_GAIN: r_batt_gain <= i_cfg_data[GAIN_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: n_state = S_START;
            S_START:  n_state = S_CALC;
            S_CALC: begin
                if (w_temp_done) begin
                    n_state = S_OUTPUT;
                end
            end
            S_OUTPUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_slot  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_UPDATE) begin
                if (!w_full) begin
                    r_fill <= r_fill + CNT_BITS'(1);
                end
                if (r_slot == SLOT_BITS'(WINDOW_LEN - 1)) begin
                    r_slot <= '0;
                end else begin
                    r_slot <= r_slot + SLOT_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_temp_sample <= i_temp_sample;
            r_batt_sample <= i_batt_sample;
        end
        if (r_state == S_UPDATE) begin
            r_divisor <= w_full ? CNT_BITS'(WINDOW_LEN) : r_fill + CNT_BITS'(1);
        end
    end

    assign w_ctrl.rd    = w_in_accept;
    assign w_ctrl.upd   = (r_state == S_UPDATE);
    assign w_ctrl.start = (r_state == S_START);
    assign w_ctrl.full  = w_full;

    dsma_channel #(
        .WINDOW_LEN  (WINDOW_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_temp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_ctrl),
        .i_slot    (r_slot),
        .i_divisor (r_divisor),
        .i_sample  (r_temp_sample),
        .i_zero    (r_temp_zero),
        .i_gain    (r_temp_gain),
        .o_product (w_temp_prod),
        .o_done    (w_temp_done)
    );

    dsma_channel #(
        .WINDOW_LEN  (WINDOW_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_batt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_ctrl),
        .i_slot    (r_slot),
        .i_divisor (r_divisor),
        .i_sample  (r_batt_sample),
        .i_zero    (r_batt_zero),
        .i_gain    (r_batt_gain),
        .o_product (w_batt_prod),
        .o_done    (w_batt_done)
    );

    // The arithmetic shift rounds the Q.16 product toward minus infinity.
    assign w_shift = w_temp_prod >>> Q_SHIFT;
    assign w_q8    = w_shift[Q8_BITS-1:0];

    always_comb begin
        if (w_q8 > Q8_MAX) begin
            w_temperature = Q8_MAX[TEMP_BITS-1:0];
        end else if (w_q8 < Q8_MIN) begin
            w_temperature = Q8_MIN[TEMP_BITS-1:0];
        end else begin
            w_temperature = w_q8[TEMP_BITS-1:0];
        end
    end

    always_comb begin
        w_level = '0;
        for (int k = 1; k <= LEVEL_COUNT; k++) begin
            if (w_batt_prod >= $signed(P_BITS'(k * LEVEL_STEP * ONE_Q16))) begin
                w_level = w_level + LEVEL_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_OUTPUT) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUTPUT) && w_out_free) begin
            r_temperature <= w_temperature;
            r_level       <= w_level;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_temperature   = r_temperature;
    assign o_battery_level = r_level;

    `DSMA_ASSERT(a_channels_lockstep, (w_temp_done == w_batt_done), "channels finished apart")
    `DSMA_ASSERT(a_done_in_calc, (w_temp_done |-> (r_state == S_CALC)), "result outside calc")
    `DSMA_ASSERT(a_load_from_output, ($rose(o_out_valid) |-> $past(r_state == S_OUTPUT)),
        "output loaded outside output state")
    `DSMA_ASSERT_ALWAYS(a_fill_bound, (!i_rst_n || (r_fill <= CNT_BITS'(WINDOW_LEN))),
        "fill count overrun")

endmodule
